// ===== rtl/core/stki_pkg.sv =====
// Shared types and constants for the stable top-k index sorter.
// No dependencies; every other file in rtl/core refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package stki_pkg;

    localparam int MAX_ITEMS_DEF   = 32;
    localparam int VALUE_WIDTH_DEF = 24;

    localparam int CFG_W    = 6;
    localparam int RANK_W   = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_TOO_FEW  = 2'd1,
        STAT_BAD      = 2'd2,
        STAT_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CTL_COLLECT,
        CTL_STATUS,
        CTL_LIST
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic shift_out;
        logic show_pos;
    } dp_cmd_t;

    // Status from the datapath, valid in the cycle of the transfer that ends a set.
    typedef struct packed {
        status_t          code;
        logic [CFG_W-1:0] count_wanted;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/stable_top_k_index_sorter_top.sv =====
// Top level of the stable top-k index sorter: controller plus insertion-chain datapath.
// Depends on stki_pkg, stki_ctrl and stki_datapath.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------------
//  cfg     | cfg_valid/cfg_ready  | cfg_data (count_wanted)
//  in      | in_valid/in_ready    | pt_value, pt_not_finite, last_item
//  out     | out_valid/out_ready  | rank_position, has_position, status, last_result
//
// While a set is collected one item is taken every cycle; each good item that fits is
// placed in the insertion chain in the cycle of its transfer, with one comparator per
// entry. After the last item the input stalls until every result of the set has been
// transferred: one status result, or count_wanted ranks at one per out_ready cycle.
// Reset clears the control state and count_wanted; the chain contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module stable_top_k_index_sorter_top #(
    parameter int MAX_ITEMS   = stki_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_WIDTH = stki_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [stki_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [VALUE_WIDTH-1:0] pt_value,
    input  logic                          pt_not_finite,
    input  logic                          last_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [stki_pkg::RANK_W-1:0]   rank_position,
    output logic                          has_position,
    output logic [stki_pkg::STATUS_W-1:0] status,
    output logic                          last_result
);

    stki_pkg::dp_cmd_t  cmd;
    stki_pkg::dp_stat_t stat;

    stki_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .last_item    (last_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .has_position (has_position),
        .status       (status),
        .last_result  (last_result),
        .cmd          (cmd),
        .stat         (stat)
    );

    stki_datapath #(
        .MAX_ITEMS   (MAX_ITEMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .pt_value      (pt_value),
        .pt_not_finite (pt_not_finite),
        .last_item     (last_item),
        .cmd           (cmd),
        .stat          (stat),
        .rank_position (rank_position)
    );

endmodule

`default_nettype wire

// ===== rtl/core/stki_datapath.sv =====
// Datapath: ordered insertion chain of values and arrival positions, set counters
// and the count_wanted register. Depends on stki_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stki_datapath #(
    parameter int MAX_ITEMS   = stki_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_WIDTH = stki_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [stki_pkg::CFG_W-1:0]    cfg_data,
    input  logic signed [VALUE_WIDTH-1:0] pt_value,
    input  logic                          pt_not_finite,
    input  logic                          last_item,
    input  stki_pkg::dp_cmd_t             cmd,
    output stki_pkg::dp_stat_t            stat,
    output logic [stki_pkg::RANK_W-1:0]   rank_position
);

    localparam int ITEM_CAP = ((MAX_ITEMS + 1) > 63) ? (MAX_ITEMS + 1) : 63;
    localparam int CNT_W    = $clog2(ITEM_CAP + 1);
    localparam int SC_W     = $clog2(MAX_ITEMS + 1);
    localparam int POS_W    = $clog2(MAX_ITEMS);

    logic [stki_pkg::CFG_W-1:0]    cw_reg;
    logic [CNT_W-1:0]              items_reg;
    logic [CNT_W-1:0]              items_next;
    logic                          bad_reg;
    logic                          bad_next;
    logic                          ovf_reg;
    logic                          ovf_next;
    logic [SC_W-1:0]               stored_reg;
    logic signed [VALUE_WIDTH-1:0] val_reg [MAX_ITEMS];
    logic [POS_W-1:0]              pos_reg [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]          lt;
    logic                          bad_in;
    logic                          in_range;
    logic                          insert;
    logic [POS_W+stki_pkg::RANK_W-1:0] pos_ext;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_reg <= '0;
        end
        else if (cfg_valid)
        begin
            cw_reg <= cfg_data;
        end
    end

    // A value is bad when flagged non-finite, negative or zero.
    assign bad_in   = pt_not_finite || pt_value[VALUE_WIDTH-1] || (pt_value == '0);
    assign in_range = items_reg < CNT_W'(MAX_ITEMS);
    assign insert   = !bad_in && in_range;

    always_comb
    begin
        items_next = (items_reg < CNT_W'(ITEM_CAP)) ? items_reg + CNT_W'(1) : items_reg;
        bad_next   = bad_reg || bad_in;
        ovf_next   = ovf_reg || !in_range;
        stat.count_wanted = cw_reg;
        if (items_next < CNT_W'(cw_reg))
        begin
            stat.code = stki_pkg::STAT_TOO_FEW;
        end
        else if (bad_next)
        begin
            stat.code = stki_pkg::STAT_BAD;
        end
        else if (ovf_next)
        begin
            stat.code = stki_pkg::STAT_OVERFLOW;
        end
        else
        begin
            stat.code = stki_pkg::STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items_reg  <= '0;
            bad_reg    <= 1'b0;
            ovf_reg    <= 1'b0;
            stored_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (last_item)
            begin
                items_reg  <= '0;
                bad_reg    <= 1'b0;
                ovf_reg    <= 1'b0;
                stored_reg <= '0;
            end
            else
            begin
                items_reg <= items_next;
                bad_reg   <= bad_next;
                ovf_reg   <= ovf_next;
                if (insert)
                begin
                    stored_reg <= stored_reg + SC_W'(1);
                end
            end
        end
    end

    // Entries past the fill count, and entries strictly below the new value, give way.
    // They form a suffix of the chain, so equal values keep their arrival order.
    always_comb
    begin
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            lt[i] = (stored_reg <= SC_W'(i)) || (val_reg[i] < pt_value);
        end
    end

    for (genvar g = 0; g < MAX_ITEMS; g++)
    begin : g_cell
        logic take_new;
        logic take_prev;

        if (g == 0)
        begin : g_head
            assign take_new  = lt[g];
            assign take_prev = 1'b0;
        end
        else
        begin : g_body
            assign take_new  = lt[g] && !lt[g-1];
            assign take_prev = lt[g] && lt[g-1];
        end

        always_ff @(posedge clk)
        begin
            if (cmd.accept && insert)
            begin
                if (take_new)
                begin
                    val_reg[g] <= pt_value;
                    pos_reg[g] <= items_reg[POS_W-1:0];
                end
                else if (take_prev)
                begin
                    val_reg[g] <= val_reg[(g == 0) ? 0 : g - 1];
                    pos_reg[g] <= pos_reg[(g == 0) ? 0 : g - 1];
                end
            end
            else if (cmd.shift_out && (g < MAX_ITEMS - 1))
            begin
                val_reg[g] <= val_reg[(g < MAX_ITEMS - 1) ? g + 1 : g];
                pos_reg[g] <= pos_reg[(g < MAX_ITEMS - 1) ? g + 1 : g];
            end
        end
    end

    assign pos_ext       = {{stki_pkg::RANK_W{1'b0}}, pos_reg[0]};
    assign rank_position = cmd.show_pos ? pos_ext[stki_pkg::RANK_W-1:0] : '0;

endmodule

`default_nettype wire

// ===== rtl/core/stki_ctrl.sv =====
// Controller: collects a set, then presents either one status result or the ranked list.
// Depends on stki_pkg; drives the datapath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module stki_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          last_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          has_position,
    output logic [stki_pkg::STATUS_W-1:0] status,
    output logic                          last_result,
    output stki_pkg::dp_cmd_t             cmd,
    input  stki_pkg::dp_stat_t            stat
);

    stki_pkg::ctl_state_t       state_reg;
    stki_pkg::ctl_state_t       state_next;
    stki_pkg::status_t          status_reg;
    stki_pkg::status_t          status_next;
    logic [stki_pkg::CFG_W-1:0] remain_reg;
    logic [stki_pkg::CFG_W-1:0] remain_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= stki_pkg::CTL_COLLECT;
            status_reg <= stki_pkg::STAT_OK;
            remain_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            remain_reg <= remain_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        status_next   = status_reg;
        remain_next   = remain_reg;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        has_position  = 1'b0;
        status        = stki_pkg::STAT_OK;
        last_result   = 1'b0;
        cmd.accept    = 1'b0;
        cmd.shift_out = 1'b0;
        cmd.show_pos  = 1'b0;
        unique case (state_reg)
            stki_pkg::CTL_COLLECT:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && last_item)
                begin
                    if ((stat.code != stki_pkg::STAT_OK) || (stat.count_wanted == '0))
                    begin
                        status_next = stat.code;
                        state_next  = stki_pkg::CTL_STATUS;
                    end
                    else
                    begin
                        remain_next = stat.count_wanted;
                        state_next  = stki_pkg::CTL_LIST;
                    end
                end
            end
            stki_pkg::CTL_STATUS:
            begin
                out_valid   = 1'b1;
                status      = status_reg;
                last_result = 1'b1;
                if (out_ready)
                begin
                    state_next = stki_pkg::CTL_COLLECT;
                end
            end
            stki_pkg::CTL_LIST:
            begin
                out_valid    = 1'b1;
                has_position = 1'b1;
                cmd.show_pos = 1'b1;
                last_result  = (remain_reg == stki_pkg::CFG_W'(1));
                if (out_ready)
                begin
                    // The head of the chain leaves and the next rank moves up.
                    cmd.shift_out = 1'b1;
                    remain_next   = remain_reg - stki_pkg::CFG_W'(1);
                    if (remain_reg == stki_pkg::CFG_W'(1))
                    begin
                        state_next = stki_pkg::CTL_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = stki_pkg::CTL_COLLECT;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output sides open at once");

    a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stki_pkg::CTL_LIST) |-> (remain_reg != '0))
        else $error("ranked list with nothing left to give");

    a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_result) |=> in_ready)
        else $error("set did not end after its final result");

    a_shift_only_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_out |-> (out_valid && out_ready && has_position))
        else $error("store shifted without a result transfer");

endmodule

`default_nettype wire
